// ===== sv/svpwm_pkg.sv =====
// ============================================================================
// svpwm_pkg - shared types and constants for the space vector PWM duty block
// Fixed-point formats, configuration register indexes and sector codes.
// ============================================================================
package svpwm_pkg;

    // default width of the raw alpha/beta voltage inputs
    localparam int VOLT_WIDTH_DEF = 16;

    // configuration register widths and reset values
    localparam int SCALE_W      = 24;
    localparam int PERIOD_W     = 16;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_IDX_W    = 1;
    localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd1048576;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd6000;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD  = 1'b1;

    // Q2.16 per-unit range
    localparam int PU_W   = 18;
    localparam int PU_MAX = 131071;
    localparam int PU_MIN = -131072;

    // sqrt(3) in Q.16
    localparam logic signed [PU_W-1:0] SQRT3_Q16 = 18'sd113512;

    // times in units of 2^-18 period; half a period
    localparam int TIME_FRAC_BITS = 18;
    localparam int T_W            = 24;
    localparam logic signed [T_W-1:0] HALF_PERIOD = 24'sd131072;

    // compare stage widths
    localparam int TPOS_W = T_W - 1;
    localparam int CPROD_W = TPOS_W + PERIOD_W;
    localparam int CMP_W  = CPROD_W - TIME_FRAC_BITS;
    localparam logic [CMP_W-1:0] MIN_COMPARE = 21'd50;

    // sector codes
    typedef enum logic [2:0] {
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5,
        SEC_6 = 3'd6
    } t_sector;

endpackage

// ===== sv/space_vector_pwm_duty.sv =====
// ============================================================================
// space_vector_pwm_duty - alpha/beta vector to three PWM compare values
// Per-unit scaling, XYZ sector search, six-case on-times, compare clamp.
// ============================================================================
// Usage:
//   Input channel: i_valid / o_stall with i_alpha_voltage, i_beta_voltage.
//   A word is taken at a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_compare_a/b/c, o_sector_number.
//   A word leaves at a clock edge with o_valid high and i_stall low.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 = voltage_scale Q4.20, 1 = timer_period); write only while idle.
//   Each accepted word passes through a seven-stage pipeline whose last
//   stage drives o_valid. Throughput: one word per cycle unless every stage
//   is full and i_stall is high; stages multiply, add, shift or clamp.
//   Each stage holds its word while the next one is full and stalled, so
//   bubbles close up and the input keeps taking words while results wait.
//   Reset (synchronous, active low) empties the pipeline and restores
//   voltage_scale = 1.0 and timer_period = 6000.
//   While i_stall is high the output word holds; o_stall rises only when
//   every stage is full.
// ============================================================================
module space_vector_pwm_duty #(
    parameter int VOLT_WIDTH = svpwm_pkg::VOLT_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [svpwm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [svpwm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [VOLT_WIDTH-1:0]          i_alpha_voltage,
    input  logic signed [VOLT_WIDTH-1:0]          i_beta_voltage,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [svpwm_pkg::PERIOD_W-1:0]        o_compare_a,
    output logic [svpwm_pkg::PERIOD_W-1:0]        o_compare_b,
    output logic [svpwm_pkg::PERIOD_W-1:0]        o_compare_c,
    output logic [2:0]                            o_sector_number
);

    localparam int NSTG   = 7;
    localparam int PROD_W = VOLT_WIDTH + svpwm_pkg::SCALE_W + 1;
    localparam int SH_W   = PROD_W - 4;
    localparam int APROD_W = 2 * svpwm_pkg::PU_W;
    localparam int A_W    = APROD_W - 16;
    localparam int H_W    = A_W + 1;
    localparam int T_W    = svpwm_pkg::T_W;
    localparam int CMP_W  = svpwm_pkg::CMP_W;
    localparam int PW     = svpwm_pkg::PERIOD_W;
    localparam logic signed [SH_W-1:0] PU_HI = SH_W'(svpwm_pkg::PU_MAX);
    localparam logic signed [SH_W-1:0] PU_LO = SH_W'(svpwm_pkg::PU_MIN);

    // configuration registers
    logic [svpwm_pkg::SCALE_W-1:0] r_voltage_scale;
    logic [PW-1:0]                 r_timer_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voltage_scale <= svpwm_pkg::SCALE_RST;
            r_timer_period  <= svpwm_pkg::PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                svpwm_pkg::CFG_VOLTAGE_SCALE:
                    r_voltage_scale <= i_cfg_data[svpwm_pkg::SCALE_W-1:0];
                svpwm_pkg::CFG_TIMER_PERIOD:
                    r_timer_period <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control: a stage loads when empty or when it drains
    logic [NSTG:1]   r_valid;
    logic [NSTG+1:1] en;

    always_comb begin
        en[NSTG+1] = !i_stall;
        for (int k = NSTG; k >= 1; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = NSTG; k >= 2; k--) begin
                if (en[k]) r_valid[k] <= r_valid[k-1];
            end
            if (en[1]) r_valid[1] <= i_valid;
        end
    end

    assign o_stall = !en[1];
    assign o_valid = r_valid[NSTG];

    // stage 1: raw voltage times Q4.20 gain
    logic signed [PROD_W-1:0] r1_prod_al, r1_prod_be;
    logic signed [svpwm_pkg::SCALE_W:0] scale_s;

    assign scale_s = $signed({1'b0, r_voltage_scale});

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_prod_al <= PROD_W'(i_alpha_voltage) * PROD_W'(scale_s);
            r1_prod_be <= PROD_W'(i_beta_voltage) * PROD_W'(scale_s);
        end
    end

    // stage 2: floor shift by 4 and saturate to Q2.16
    logic signed [SH_W-1:0]           sh_al, sh_be;
    logic signed [svpwm_pkg::PU_W-1:0] n2_al, n2_be, r2_al, r2_be;

    always_comb begin
        sh_al = SH_W'(r1_prod_al >>> 4);
        sh_be = SH_W'(r1_prod_be >>> 4);
        if (sh_al > PU_HI)      n2_al = svpwm_pkg::PU_W'(svpwm_pkg::PU_MAX);
        else if (sh_al < PU_LO) n2_al = svpwm_pkg::PU_W'(svpwm_pkg::PU_MIN);
        else                    n2_al = sh_al[svpwm_pkg::PU_W-1:0];
        if (sh_be > PU_HI)      n2_be = svpwm_pkg::PU_W'(svpwm_pkg::PU_MAX);
        else if (sh_be < PU_LO) n2_be = svpwm_pkg::PU_W'(svpwm_pkg::PU_MIN);
        else                    n2_be = sh_be[svpwm_pkg::PU_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_al <= n2_al;
            r2_be <= n2_be;
        end
    end

    // stage 3: sqrt(3) * alpha, floor to Q.16
    logic signed [APROD_W-1:0]         aprod;
    logic signed [A_W-1:0]             r3_a;
    logic signed [svpwm_pkg::PU_W-1:0] r3_be;

    assign aprod = APROD_W'(svpwm_pkg::SQRT3_Q16) * APROD_W'(r2_al);

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_a  <= aprod[APROD_W-1:16];
            r3_be <= r2_be;
        end
    end

    // stage 4: half of X, Y, Z and the sector from their signs
    logic signed [H_W-1:0] n4_hx, n4_hy, n4_hz, r4_hx, r4_hy, r4_hz;
    svpwm_pkg::t_sector    n4_sec, r4_sec;

    always_comb begin
        n4_hx = H_W'(r3_be) <<< 1;
        n4_hy = H_W'(r3_a) + H_W'(r3_be);
        n4_hz = H_W'(r3_be) - H_W'(r3_a);
        if (n4_hy < 0) begin
            if (n4_hz < 0)       n4_sec = svpwm_pkg::SEC_5;
            else if (r3_be < 0)  n4_sec = svpwm_pkg::SEC_4;
            else                 n4_sec = svpwm_pkg::SEC_3;
        end else begin
            if (n4_hz > 0)       n4_sec = svpwm_pkg::SEC_2;
            else if (r3_be < 0)  n4_sec = svpwm_pkg::SEC_6;
            else                 n4_sec = svpwm_pkg::SEC_1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_hx  <= n4_hx;
            r4_hy  <= n4_hy;
            r4_hz  <= n4_hz;
            r4_sec <= n4_sec;
        end
    end

    // stage 5: phase on-times, each half period plus two half terms
    logic signed [T_W-1:0] hx, hy, hz, n5_ta, n5_tb, n5_tc;
    logic signed [T_W-1:0] r5_ta, r5_tb, r5_tc;
    svpwm_pkg::t_sector    r5_sec;

    always_comb begin
        hx = T_W'(r4_hx);
        hy = T_W'(r4_hy);
        hz = T_W'(r4_hz);
        case (r4_sec)
            svpwm_pkg::SEC_1: begin
                n5_ta = svpwm_pkg::HALF_PERIOD + hx - hz;
                n5_tb = svpwm_pkg::HALF_PERIOD + hx + hz;
                n5_tc = svpwm_pkg::HALF_PERIOD + hz - hx;
            end
            svpwm_pkg::SEC_2: begin
                n5_ta = svpwm_pkg::HALF_PERIOD + hy - hz;
                n5_tb = svpwm_pkg::HALF_PERIOD + hy + hz;
                n5_tc = svpwm_pkg::HALF_PERIOD - hy - hz;
            end
            svpwm_pkg::SEC_3: begin
                n5_ta = svpwm_pkg::HALF_PERIOD + hy - hx;
                n5_tb = svpwm_pkg::HALF_PERIOD + hx - hy;
                n5_tc = svpwm_pkg::HALF_PERIOD - hx - hy;
            end
            svpwm_pkg::SEC_4: begin
                n5_ta = svpwm_pkg::HALF_PERIOD + hx - hz;
                n5_tb = svpwm_pkg::HALF_PERIOD + hx + hz;
                n5_tc = svpwm_pkg::HALF_PERIOD + hz - hx;
            end
            svpwm_pkg::SEC_5: begin
                n5_ta = svpwm_pkg::HALF_PERIOD + hy - hz;
                n5_tb = svpwm_pkg::HALF_PERIOD + hy + hz;
                n5_tc = svpwm_pkg::HALF_PERIOD - hy - hz;
            end
            default: begin
                n5_ta = svpwm_pkg::HALF_PERIOD + hy - hx;
                n5_tb = svpwm_pkg::HALF_PERIOD + hx - hy;
                n5_tc = svpwm_pkg::HALF_PERIOD - hx - hy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_ta  <= n5_ta;
            r5_tb  <= n5_tb;
            r5_tc  <= n5_tc;
            r5_sec <= r4_sec;
        end
    end

    // stage 6: on-time times timer period; remember non-positive times
    localparam int TP_W = svpwm_pkg::TPOS_W;
    localparam int CP_W = svpwm_pkg::CPROD_W;
    logic [CP_W-1:0]    r6_pa, r6_pb, r6_pc;
    logic               r6_za, r6_zb, r6_zc;
    svpwm_pkg::t_sector r6_sec;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_pa  <= CP_W'(r5_ta[TP_W-1:0]) * CP_W'(r_timer_period);
            r6_pb  <= CP_W'(r5_tb[TP_W-1:0]) * CP_W'(r_timer_period);
            r6_pc  <= CP_W'(r5_tc[TP_W-1:0]) * CP_W'(r_timer_period);
            r6_za  <= (r5_ta <= 0);
            r6_zb  <= (r5_tb <= 0);
            r6_zc  <= (r5_tc <= 0);
            r6_sec <= r5_sec;
        end
    end

    // stage 7: truncate, clamp low to 50, then clamp high to the period
    function automatic logic [PW-1:0] clamp_cmp(input logic [CP_W-1:0] prod,
                                                input logic nonpos,
                                                input logic [PW-1:0] period);
        logic [CMP_W-1:0] c;
        logic [CMP_W-1:0] per;
        c   = nonpos ? '0 : prod[CP_W-1:svpwm_pkg::TIME_FRAC_BITS];
        per = CMP_W'(period);
        if (c < svpwm_pkg::MIN_COMPARE) c = svpwm_pkg::MIN_COMPARE;
        if (c > per) c = per;
        return c[PW-1:0];
    endfunction

    logic [PW-1:0] r7_ca, r7_cb, r7_cc;
    logic [2:0]    r7_sec;

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_ca  <= clamp_cmp(r6_pa, r6_za, r_timer_period);
            r7_cb  <= clamp_cmp(r6_pb, r6_zb, r_timer_period);
            r7_cc  <= clamp_cmp(r6_pc, r6_zc, r_timer_period);
            r7_sec <= r6_sec;
        end
    end

    assign o_compare_a     = r7_ca;
    assign o_compare_b     = r7_cb;
    assign o_compare_c     = r7_cc;
    assign o_sector_number = r7_sec;

`ifndef NO_ASSERTIONS
    // compare values never exceed the timer period
    a_cmp_le_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_compare_a <= r_timer_period) && (o_compare_b <= r_timer_period)
                    && (o_compare_c <= r_timer_period))
        else $error("compare value above timer period");

    // an accepted word always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_valid[1])
        else $error("accepted word lost at pipeline entry");

    // with the output draining, the input is never stalled
    a_no_stall_when_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

    // input is stalled only when every stage holds a word
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_valid == '1))
        else $error("input stalled with an empty stage");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top - testbench for space_vector_pwm_duty
// Drives alpha/beta voltage words through the duty block with random idle
// and stall on both channels, predicts the three compare values and the
// sector for each accepted word, and checks every result word in order.
// Register settings change between phases while the pipeline is empty.
// ============================================================================
module tb_top;

    localparam int VW        = 16;
    localparam int LATENCY   = 7;
    localparam int IDLE_PCT  = 31;
    localparam int PW        = svpwm_pkg::PERIOD_W;
    localparam int SW        = svpwm_pkg::SCALE_W;

    // expected result word
    typedef struct {
        logic [PW-1:0]      cmp_a;
        logic [PW-1:0]      cmp_b;
        logic [PW-1:0]      cmp_c;
        svpwm_pkg::t_sector sector;
    } t_duty_word;

    // ------------------------------------------------------------------------
    // Scoreboard: duty predictor plus queue of pending compare words
    // ------------------------------------------------------------------------
    class t_svpwm_scoreboard;
        bit [SW-1:0]  scale  = svpwm_pkg::SCALE_RST;
        bit [PW-1:0]  period = svpwm_pkg::PERIOD_RST;
        t_duty_word   duty_q[$];
        int           errors = 0;

        // raw volts to Q2.16 per-unit, saturated
        function longint per_unit(longint v);
            longint p;
            p = (v * longint'(scale)) >>> 4;
            if (p > svpwm_pkg::PU_MAX) p = svpwm_pkg::PU_MAX;
            if (p < svpwm_pkg::PU_MIN) p = svpwm_pkg::PU_MIN;
            return p;
        endfunction

        // on-time in 2^-18 period units to clamped compare value
        function logic [PW-1:0] on_time_to_compare(longint t);
            longint c;
            if (t <= 0)
                c = 0;
            else
                c = (t * longint'(period)) >> svpwm_pkg::TIME_FRAC_BITS;
            if (c < svpwm_pkg::MIN_COMPARE) c = svpwm_pkg::MIN_COMPARE;
            if (c > period) c = period;
            return c[PW-1:0];
        endfunction

        // accepted input word: compute its duty word
        function void note_vector(logic signed [VW-1:0] alpha, logic signed [VW-1:0] beta);
            longint             al, be, a_term, x, y, z, half, ta, tb, tc;
            svpwm_pkg::t_sector sec;
            t_duty_word         w;
            al     = per_unit(longint'(alpha));
            be     = per_unit(longint'(beta));
            a_term = (longint'(svpwm_pkg::SQRT3_Q16) * al) >>> 16;
            x      = 4 * be;
            y      = 2 * (a_term + be);
            z      = 2 * (be - a_term);
            half   = longint'(svpwm_pkg::HALF_PERIOD);

            // sector from signs; ties on Y and X go non-negative, Z tie goes low if Y >= 0
            if (y < 0) begin
                if (z < 0)
                    sec = svpwm_pkg::SEC_5;
                else
                    sec = (x < 0) ? svpwm_pkg::SEC_4 : svpwm_pkg::SEC_3;
            end else begin
                if (z > 0)
                    sec = svpwm_pkg::SEC_2;
                else
                    sec = (x < 0) ? svpwm_pkg::SEC_6 : svpwm_pkg::SEC_1;
            end

            case (sec)
                svpwm_pkg::SEC_1: begin
                    ta = half + (x - z) / 2;
                    tb = ta + z;
                    tc = tb - x;
                end
                svpwm_pkg::SEC_2: begin
                    tb = half + (z + y) / 2;
                    ta = tb - z;
                    tc = ta - y;
                end
                svpwm_pkg::SEC_3: begin
                    tb = half + (x - y) / 2;
                    tc = tb - x;
                    ta = tc + y;
                end
                svpwm_pkg::SEC_4: begin
                    tc = half + (z - x) / 2;
                    tb = tc + x;
                    ta = tb - z;
                end
                svpwm_pkg::SEC_5: begin
                    tc = half + (-y - z) / 2;
                    ta = tc + y;
                    tb = ta + z;
                end
                default: begin
                    ta = half + (y - x) / 2;
                    tc = ta - y;
                    tb = tc + x;
                end
            endcase

            w.cmp_a  = on_time_to_compare(ta);
            w.cmp_b  = on_time_to_compare(tb);
            w.cmp_c  = on_time_to_compare(tc);
            w.sector = sec;
            duty_q.push_back(w);
        endfunction

        // accepted result word: compare with the oldest expectation
        function void check_duty(logic [PW-1:0] cmp_a, logic [PW-1:0] cmp_b,
                                 logic [PW-1:0] cmp_c, logic [2:0] sector);
            t_duty_word w;
            if (duty_q.size() == 0) begin
                $display("%0t: unexpected result word a=%0d b=%0d c=%0d sector=%0d",
                         $time, cmp_a, cmp_b, cmp_c, sector);
                errors++;
                return;
            end
            w = duty_q.pop_front();
            if (cmp_a !== w.cmp_a) begin
                $display("%0t: compare_a expected %0d actual %0d", $time, w.cmp_a, cmp_a);
                errors++;
            end
            if (cmp_b !== w.cmp_b) begin
                $display("%0t: compare_b expected %0d actual %0d", $time, w.cmp_b, cmp_b);
                errors++;
            end
            if (cmp_c !== w.cmp_c) begin
                $display("%0t: compare_c expected %0d actual %0d", $time, w.cmp_c, cmp_c);
                errors++;
            end
            if (sector !== w.sector) begin
                $display("%0t: sector expected %0d actual %0d", $time, w.sector, sector);
                errors++;
            end
        endfunction

        function int pending();
            return duty_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [svpwm_pkg::CFG_IDX_W-1:0]   i_cfg_index = svpwm_pkg::CFG_VOLTAGE_SCALE;
    logic [svpwm_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic signed [VW-1:0]              i_alpha_voltage = '0;
    logic signed [VW-1:0]              i_beta_voltage = '0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic [PW-1:0]                     o_compare_a;
    logic [PW-1:0]                     o_compare_b;
    logic [PW-1:0]                     o_compare_c;
    logic [2:0]                        o_sector_number;

    bit                                idle_on = 1'b1;
    t_svpwm_scoreboard                 sb = new();

    space_vector_pwm_duty #(
        .VOLT_WIDTH      (VW)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_alpha_voltage (i_alpha_voltage),
        .i_beta_voltage  (i_beta_voltage),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_compare_a     (o_compare_a),
        .o_compare_b     (o_compare_b),
        .o_compare_c     (o_compare_c),
        .o_sector_number (o_sector_number)
    );

    always #5 i_clk = ~i_clk;

    // output side: random stall, check every word that leaves
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_duty(o_compare_a, o_compare_b, o_compare_c, o_sector_number);
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // send one voltage word, holding it until accepted
    task automatic send_vector(input logic signed [VW-1:0] alpha,
                               input logic signed [VW-1:0] beta);
        while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_alpha_voltage <= alpha;
        i_beta_voltage  <= beta;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_vector(alpha, beta);
    endtask

    // hold the sender until all pending words are out, then let the pipe settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    // write both registers while the block is empty
    task automatic set_config(input logic [SW-1:0] scale,
                              input logic [PW-1:0] period);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= svpwm_pkg::CFG_VOLTAGE_SCALE;
        i_cfg_data  <= svpwm_pkg::CFG_DATA_W'(scale);
        @(posedge i_clk);
        i_cfg_index <= svpwm_pkg::CFG_TIMER_PERIOD;
        i_cfg_data  <= svpwm_pkg::CFG_DATA_W'(period);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.scale  = scale;
        sb.period = period;
    endtask

    // voltage mix: full range, small magnitudes and edge values
    function automatic logic signed [VW-1:0] pick_volt();
        logic signed [VW-1:0] v;
        case ($urandom_range(3))
            0: v = VW'($urandom_range(4000)) - VW'(2000);
            1: begin
                case ($urandom_range(4))
                    0: v = 16'sh7FFF;
                    1: v = 16'sh8000;
                    2: v = '0;
                    3: v = -16'sd1;
                    default: v = 16'sd1;
                endcase
            end
            default: v = VW'($urandom());
        endcase
        return v;
    endfunction

    task automatic run_random(input logic [SW-1:0] scale,
                              input logic [PW-1:0] period,
                              input int count, input bit with_idle);
        set_config(scale, period);
        idle_on = with_idle;
        repeat (count) send_vector(pick_volt(), pick_volt());
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings (gain 1.0): extremes saturate per-unit values
        send_vector(16'sd0, 16'sd0);
        send_vector(16'sh7FFF, 16'sh7FFF);
        send_vector(16'sh8000, 16'sh8000);
        send_vector(16'sh7FFF, 16'sh8000);
        send_vector(16'sh8000, 16'sh7FFF);
        send_vector(16'sd1, 16'sd0);
        send_vector(-16'sd1, -16'sd1);

        // gain 1/65536: per-unit equals raw, so sign ties can be hit exactly
        set_config(24'd16, 16'd6000);
        send_vector(16'sd1000, 16'sd300);      // sector 1
        send_vector(16'sd0, 16'sd1000);        // sector 2
        send_vector(-16'sd1000, 16'sd300);     // sector 3
        send_vector(-16'sd1000, -16'sd300);    // sector 4
        send_vector(16'sd0, -16'sd1000);       // sector 5
        send_vector(16'sd1000, -16'sd300);     // sector 6
        send_vector(16'sd1000, -16'sd1732);    // Y exactly zero
        send_vector(16'sd1000, 16'sd1732);     // Z exactly zero
        send_vector(16'sd1000, 16'sd0);        // X zero, Y positive
        send_vector(-16'sd1000, 16'sd0);       // X zero, Y negative
        send_vector(16'sh7FFF, 16'sd0);
        send_vector(16'sd0, 16'sh8000);

        // random phases over the register range
        run_random(24'd32, 16'd6000, 250, 1'b1);
        run_random(24'd64, 16'd65535, 200, 1'b1);
        run_random(24'hFFFFFF, 16'd51, 150, 1'b1);
        run_random(24'd0, 16'd1000, 50, 1'b1);
        run_random(24'($urandom_range(96, 8)), 16'd30, 100, 1'b1);   // period under 50
        run_random(24'd40, 16'($urandom_range(65535, 51)), 300, 1'b0);
        run_random(24'($urandom()), 16'($urandom_range(65535, 51)), 100, 1'b1);
        run_random(24'($urandom_range(48, 16)), 16'($urandom_range(65535, 51)), 250, 1'b1);

        // wait out the pipeline, then a margin for stray words
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY * 3) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
